// ----- hdl/ccqh_pkg.sv -----
`timescale 1ns / 1ps

package ccqh_pkg;

  // default depth of the clip profile and the mapped-length histogram
  localparam int unsigned ProfileBinsDef = 16384;

  // mapping quality histogram
  localparam int unsigned QualBins = 256;
  localparam int unsigned QualAw   = 8;

  // counter width of every histogram and profile entry
  localparam int unsigned CountW = 32;

  // bam cigar operation codes
  localparam logic [3:0] CigM  = 4'd0;
  localparam logic [3:0] CigI  = 4'd1;
  localparam logic [3:0] CigS  = 4'd4;
  localparam logic [3:0] CigEq = 4'd7;
  localparam logic [3:0] CigX  = 4'd8;

  typedef enum logic {
    OP_ELEMENT = 1'b0,
    OP_READOUT = 1'b1
  } req_op_e;

  typedef enum logic [8:0] {
    ST_CLEAR   = 9'b000000001,
    ST_IDLE    = 9'b000000010,
    ST_CLIP_RD = 9'b000000100,
    ST_CLIP_WR = 9'b000001000,
    ST_EOR_RD  = 9'b000010000,
    ST_EOR_WQ  = 9'b000100000,
    ST_EOR_WM  = 9'b001000000,
    ST_RD_REQ  = 9'b010000000,
    ST_RD_DATA = 9'b100000000
  } state_e;

endpackage

// ----- hdl/cigar_clip_and_quality_histogram_top.sv -----
`timescale 1ns / 1ps
// soft-clip profile, mapping quality and mapped-length histograms from bam cigar words.
// input channel (in_valid_i / in_ready_o): one request per cigar element of a read
// (op_i = 0, end_of_read_i on the last element) or one readout of a bin (op_i = 1).
// output channel (out_valid_o / out_ready_i): one result per readout request only.
// work per request, all done by one read-modify-write port per counter memory
// and one shared 32-bit incrementer:
//   plain element: no extra work; soft clip: a read and a write per clipped base inside
//   the table; last element of a read: quality bin, then mapped-length bin written;
//   readout: all three memories read, result registered, then new requests are taken.
// the result sits in an output register, so element requests keep flowing while
// the receiver stalls; a second readout waits until that register is taken.
// after reset all three counter memories are cleared one entry a cycle, and in_ready_o
// stays low until that pass is done.

module cigar_clip_and_quality_histogram_top #(
  parameter int unsigned PROFILE_BINS = ccqh_pkg::ProfileBinsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        op_i,
  input  logic [31:0] cigar_word_i,
  input  logic        end_of_read_i,
  input  logic [7:0]  map_quality_i,
  input  logic [15:0] query_length_i,
  input  logic [13:0] bin_index_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] clip_count_o,
  output logic [31:0] quality_count_o,
  output logic [31:0] mapped_length_count_o,
  output logic [15:0] longest_read_o
);

  import ccqh_pkg::*;

  localparam int unsigned PW      = $clog2(PROFILE_BINS);
  localparam int unsigned PcW     = PW + 1;
  localparam int unsigned BinExtW = (PW > 14) ? PW : 14;

  state_e state_q, state_d;

  logic [PW-1:0]     clr_q, clr_d;
  logic [31:0]       qpos_q, qpos_d;
  logic [31:0]       msum_q, msum_d;
  logic [15:0]       longest_q, longest_d;
  logic [PcW-1:0]    clip_pos_q, clip_pos_d;
  logic [PcW-1:0]    clip_end_q, clip_end_d;
  logic              last_q, last_d;
  logic [QualAw-1:0] mapq_q, mapq_d;
  logic [13:0]       bin_q, bin_d;

  logic              out_valid_q, out_valid_d;
  logic [31:0]       clip_out_q, clip_out_d;
  logic [31:0]       qual_out_q, qual_out_d;
  logic [31:0]       mlen_out_q, mlen_out_d;
  logic [15:0]       long_out_q, long_out_d;

  // element decode
  logic        accept;
  logic [3:0]  code;
  logic [27:0] len;
  logic        advances;
  logic [32:0] qpos_sum;
  logic [32:0] msum_sum;
  logic [PcW-1:0] clip_hi;
  logic        clip_any;
  logic [PcW-1:0] clip_nxt;

  // memory ports
  logic          clip_we, qual_we, mlen_we;
  logic          clip_re, qual_re, mlen_re;
  logic [PW-1:0] clip_waddr, clip_raddr, mlen_waddr, mlen_raddr;
  logic [QualAw-1:0] qual_waddr, qual_raddr;
  logic [CountW-1:0] wdata;
  logic [CountW-1:0] clip_rdata, qual_rdata, mlen_rdata;

  logic [CountW-1:0] inc_in, inc_out;
  logic [PW-1:0]     mlen_bin;
  logic [BinExtW-1:0] bin_ext;
  logic [PW-1:0]     bin_addr;
  logic              bin_in_profile, bin_in_qual;
  logic              out_free;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i & in_ready_o;

  assign code     = cigar_word_i[3:0];
  assign len      = cigar_word_i[31:4];
  assign advances = (code == CigM) || (code == CigI) || (code == CigS) ||
                    (code == CigEq) || (code == CigX);
  assign qpos_sum = {1'b0, qpos_q} + 33'(len);
  assign msum_sum = {1'b0, msum_q} + 33'(len);

  // clip span is clamped to the end of the table
  assign clip_hi  = (qpos_sum > 33'(PROFILE_BINS)) ? PcW'(PROFILE_BINS)
                                                   : qpos_sum[PcW-1:0];
  assign clip_any = (code == CigS) && (qpos_q < 32'(PROFILE_BINS)) &&
                    (PcW'(qpos_q) < clip_hi);
  assign clip_nxt = clip_pos_q + PcW'(1);

  assign mlen_bin = (msum_q >= 32'(PROFILE_BINS)) ? PW'(PROFILE_BINS - 1)
                                                  : msum_q[PW-1:0];

  assign bin_ext        = BinExtW'(bin_q);
  assign bin_addr       = bin_ext[PW-1:0];
  assign bin_in_profile = 32'(bin_q) < 32'(PROFILE_BINS);
  assign bin_in_qual    = 32'(bin_q) < 32'(QualBins);

  assign out_free = !out_valid_q || out_ready_i;

  // shared counter incrementer
  always_comb begin
    case (1'b1)
      state_q[3]: inc_in = clip_rdata;  // clip write
      state_q[5]: inc_in = qual_rdata;  // quality write
      default:    inc_in = mlen_rdata;
    endcase
  end
  assign inc_out = inc_in + CountW'(1);
  assign wdata   = (state_q == ST_CLEAR) ? '0 : inc_out;

  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    qpos_d     = qpos_q;
    msum_d     = msum_q;
    longest_d  = longest_q;
    clip_pos_d = clip_pos_q;
    clip_end_d = clip_end_q;
    last_d     = last_q;
    mapq_d     = mapq_q;
    bin_d      = bin_q;

    out_valid_d = out_valid_q && !out_ready_i;
    clip_out_d  = clip_out_q;
    qual_out_d  = qual_out_q;
    mlen_out_d  = mlen_out_q;
    long_out_d  = long_out_q;

    clip_we    = 1'b0;
    qual_we    = 1'b0;
    mlen_we    = 1'b0;
    clip_re    = 1'b0;
    qual_re    = 1'b0;
    mlen_re    = 1'b0;
    clip_waddr = clip_pos_q[PW-1:0];
    clip_raddr = clip_pos_q[PW-1:0];
    qual_waddr = mapq_q;
    qual_raddr = mapq_q;
    mlen_waddr = mlen_bin;
    mlen_raddr = mlen_bin;

    unique case (state_q)
      ST_CLEAR: begin
        clip_we    = 1'b1;
        qual_we    = 1'b1;
        mlen_we    = 1'b1;
        clip_waddr = clr_q;
        qual_waddr = clr_q[QualAw-1:0];
        mlen_waddr = clr_q;
        clr_d      = clr_q + PW'(1);
        if (clr_q == PW'(PROFILE_BINS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (op_i == OP_READOUT) begin
            bin_d   = bin_index_i;
            state_d = ST_RD_REQ;
          end else begin
            last_d     = end_of_read_i;
            mapq_d     = map_quality_i;
            clip_pos_d = PcW'(qpos_q);
            clip_end_d = clip_hi;
            if (advances) begin
              qpos_d = qpos_sum[31:0];
            end
            if (code == CigM) begin
              msum_d = msum_sum[32] ? '1 : msum_sum[31:0];
            end
            if (end_of_read_i && (query_length_i > longest_q)) begin
              longest_d = query_length_i;
            end
            if (clip_any) begin
              state_d = ST_CLIP_RD;
            end else if (end_of_read_i) begin
              state_d = ST_EOR_RD;
            end
          end
        end
      end
      ST_CLIP_RD: begin
        clip_re = 1'b1;
        state_d = ST_CLIP_WR;
      end
      ST_CLIP_WR: begin
        clip_we    = 1'b1;
        clip_pos_d = clip_nxt;
        if (clip_nxt < clip_end_q) begin
          state_d = ST_CLIP_RD;
        end else if (last_q) begin
          state_d = ST_EOR_RD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_EOR_RD: begin
        qual_re = 1'b1;
        mlen_re = 1'b1;
        state_d = ST_EOR_WQ;
      end
      ST_EOR_WQ: begin
        qual_we = 1'b1;
        state_d = ST_EOR_WM;
      end
      ST_EOR_WM: begin
        mlen_we = 1'b1;
        qpos_d  = '0;
        msum_d  = '0;
        state_d = ST_IDLE;
      end
      ST_RD_REQ: begin
        clip_re    = 1'b1;
        qual_re    = 1'b1;
        mlen_re    = 1'b1;
        clip_raddr = bin_addr;
        qual_raddr = bin_q[QualAw-1:0];
        mlen_raddr = bin_addr;
        state_d    = ST_RD_DATA;
      end
      ST_RD_DATA: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          clip_out_d  = bin_in_profile ? clip_rdata : '0;
          qual_out_d  = bin_in_qual ? qual_rdata : '0;
          mlen_out_d  = bin_in_profile ? mlen_rdata : '0;
          long_out_d  = longest_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      qpos_q      <= '0;
      msum_q      <= '0;
      longest_q   <= '0;
      clip_pos_q  <= '0;
      clip_end_q  <= '0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      qpos_q      <= qpos_d;
      msum_q      <= msum_d;
      longest_q   <= longest_d;
      clip_pos_q  <= clip_pos_d;
      clip_end_q  <= clip_end_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mapq_q     <= mapq_d;
    bin_q      <= bin_d;
    clip_out_q <= clip_out_d;
    qual_out_q <= qual_out_d;
    mlen_out_q <= mlen_out_d;
    long_out_q <= long_out_d;
  end

  ccqh_ram #(
    .DEPTH (PROFILE_BINS),
    .WIDTH (CountW),
    .AW    (PW)
  ) u_clip_ram (
    .clk_i   (clk_i),
    .we_i    (clip_we),
    .waddr_i (clip_waddr),
    .wdata_i (wdata),
    .re_i    (clip_re),
    .raddr_i (clip_raddr),
    .rdata_o (clip_rdata)
  );

  ccqh_ram #(
    .DEPTH (QualBins),
    .WIDTH (CountW),
    .AW    (QualAw)
  ) u_qual_ram (
    .clk_i   (clk_i),
    .we_i    (qual_we),
    .waddr_i (qual_waddr),
    .wdata_i (wdata),
    .re_i    (qual_re),
    .raddr_i (qual_raddr),
    .rdata_o (qual_rdata)
  );

  ccqh_ram #(
    .DEPTH (PROFILE_BINS),
    .WIDTH (CountW),
    .AW    (PW)
  ) u_mlen_ram (
    .clk_i   (clk_i),
    .we_i    (mlen_we),
    .waddr_i (mlen_waddr),
    .wdata_i (wdata),
    .re_i    (mlen_re),
    .raddr_i (mlen_raddr),
    .rdata_o (mlen_rdata)
  );

  assign out_valid_o           = out_valid_q;
  assign clip_count_o          = clip_out_q;
  assign quality_count_o       = qual_out_q;
  assign mapped_length_count_o = mlen_out_q;
  assign longest_read_o        = long_out_q;

endmodule

// ----- hdl/ccqh_ram.sv -----
`timescale 1ns / 1ps

module ccqh_ram #(
  parameter int unsigned DEPTH = ccqh_pkg::QualBins,
  parameter int unsigned WIDTH = ccqh_pkg::CountW,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
